[hdl/cws_pkg.sv]
// shared types, constants and codes for the comment and whitespace stripper
// no dependencies; used by cws_step, cws_result_fifo and the top level
package cws_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_MASK = 8'hdf;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4,
    MODE_STRING     = 3'd5,
    MODE_STR_ESC    = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] kept_byte;
    logic       has_byte;
    logic       final_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    mode_t      mode_next;
  } step_out_t;

endpackage

[hdl/cws_step.sv]
// combinational scan step: one text byte and the scan mode in, up to two results out
// depends on cws_pkg
module cws_step (
  input  cws_pkg::mode_t     mode,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output cws_pkg::step_out_t step
);

  logic           lead_slash;
  logic           keep_byte;
  logic           tail_slash;
  logic           run_normal;
  logic [7:0]     out_byte;
  cws_pkg::mode_t mode_mid;
  cws_pkg::result_t slash_res;
  cws_pkg::result_t byte_res;
  logic [1:0]     total;

  always_comb begin
    lead_slash = 1'b0;
    run_normal = 1'b0;
    keep_byte  = 1'b0;
    out_byte   = text_byte;
    mode_mid   = mode;
    unique case (mode)
      cws_pkg::MODE_SLASH: begin
        if (text_byte == cws_pkg::CH_STAR) begin
          mode_mid = cws_pkg::MODE_BLOCK;
        end else if (text_byte == cws_pkg::CH_SLASH) begin
          mode_mid = cws_pkg::MODE_LINE;
        end else begin
          lead_slash = 1'b1;
          run_normal = 1'b1;
        end
      end
      cws_pkg::MODE_BLOCK: begin
        if (text_byte == cws_pkg::CH_STAR) mode_mid = cws_pkg::MODE_BLOCK_STAR;
      end
      cws_pkg::MODE_BLOCK_STAR: begin
        if (text_byte == cws_pkg::CH_SLASH) begin
          mode_mid = cws_pkg::MODE_NORMAL;
        end else if (text_byte != cws_pkg::CH_STAR) begin
          mode_mid = cws_pkg::MODE_BLOCK;
        end
      end
      cws_pkg::MODE_LINE: begin
        if (text_byte == cws_pkg::CH_NL) mode_mid = cws_pkg::MODE_NORMAL;
      end
      cws_pkg::MODE_STRING: begin
        keep_byte = 1'b1;
        if (text_byte == cws_pkg::CH_QUOTE) begin
          mode_mid = cws_pkg::MODE_NORMAL;
        end else if (text_byte == cws_pkg::CH_PCT) begin
          mode_mid = cws_pkg::MODE_STR_ESC;
        end
      end
      cws_pkg::MODE_STR_ESC: begin
        keep_byte = 1'b1;
        mode_mid  = cws_pkg::MODE_STRING;
      end
      default: begin
        run_normal = 1'b1;
      end
    endcase

    // plain text handling, also reached after a released slash
    if (run_normal) begin
      mode_mid = cws_pkg::MODE_NORMAL;
      if (text_byte <= cws_pkg::CH_SPACE || text_byte >= cws_pkg::CH_HIGH) begin
        keep_byte = 1'b0;
      end else if (text_byte == cws_pkg::CH_SLASH) begin
        mode_mid = cws_pkg::MODE_SLASH;
      end else if (text_byte == cws_pkg::CH_QUOTE) begin
        keep_byte = 1'b1;
        mode_mid  = cws_pkg::MODE_STRING;
      end else begin
        keep_byte = 1'b1;
        if (text_byte >= cws_pkg::CH_LOW_A && text_byte <= cws_pkg::CH_LOW_Z) begin
          out_byte = text_byte & cws_pkg::CASE_MASK;
        end
      end
    end

    tail_slash = end_of_text && (mode_mid == cws_pkg::MODE_SLASH);

    slash_res = '{kept_byte: cws_pkg::CH_SLASH, has_byte: 1'b1, final_result: 1'b0};
    byte_res  = '{kept_byte: out_byte, has_byte: 1'b1, final_result: 1'b0};

    // a kept byte and a flushed slash never occur together
    total = {1'b0, lead_slash} + {1'b0, keep_byte} + {1'b0, tail_slash};

    step.res0 = '0;
    step.res1 = '0;
    if (lead_slash) begin
      step.res0 = slash_res;
      if (keep_byte) step.res1 = byte_res;
      else if (tail_slash) step.res1 = slash_res;
    end else if (keep_byte) begin
      step.res0 = byte_res;
    end else if (tail_slash) begin
      step.res0 = slash_res;
    end

    step.count = total;
    if (end_of_text) begin
      if (total == 2'd2) begin
        step.res1.final_result = 1'b1;
      end else begin
        step.count             = 2'd1;
        step.res0.final_result = 1'b1;
      end
    end

    step.mode_next = end_of_text ? cws_pkg::MODE_NORMAL : mode_mid;
  end

endmodule

[hdl/cws_result_fifo.sv]
// small result queue: takes up to two results a cycle, gives one a cycle while rd_ready is high
// depends on cws_pkg
module cws_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_count,
  input  cws_pkg::result_t wr_res0,
  input  cws_pkg::result_t wr_res1,
  output logic             room_for_two,
  output logic             rd_valid,
  input  logic             rd_ready,
  output cws_pkg::result_t rd_res,
  output logic [cws_pkg::FIFO_CNT_W-1:0] fill
);

  cws_pkg::result_t entries [cws_pkg::FIFO_DEPTH];
  logic [cws_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cws_pkg::FIFO_CNT_W-1:0] fill_next;
  logic rd_take;

  assign rd_valid     = (fill != '0);
  assign rd_res       = entries[rd_ptr];
  assign rd_take      = rd_valid && rd_ready;
  assign room_for_two = fill <= cws_pkg::FIFO_CNT_W'(cws_pkg::FIFO_DEPTH - 2);
  assign fill_next    = fill + cws_pkg::FIFO_CNT_W'(wr_count)
                      - cws_pkg::FIFO_CNT_W'(rd_take);

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) entries[wr_ptr] <= wr_res0;
    if (wr_count == 2'd2) entries[wr_ptr + cws_pkg::FIFO_PTR_W'(1)] <= wr_res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + cws_pkg::FIFO_PTR_W'(wr_count);
      rd_ptr <= rd_ptr + cws_pkg::FIFO_PTR_W'(rd_take);
      fill   <= fill_next;
    end
  end

endmodule

[hdl/comment_whitespace_stripper_unit.sv]
// top level of the comment and whitespace stripper: input register, scan step, result queue
// depends on cws_pkg, cws_step and cws_result_fifo
//
//   channel   | direction | tdata           | tuser    | tlast
//   s_axis    | in        | text_byte[7:0]  | -        | end_of_text
//   m_axis    | out       | kept_byte[7:0]  | has_byte | final_result
//
// one text byte a cycle is taken while the queue has room; a byte gives zero, one or two output transactions
// when the queue is empty, a byte passes the input register and then the queue before its first output
// throughput is set by the output side: one result a cycle while m_axis_tready is high, out of a four-entry queue
// a byte leaves the input register only when the queue has room for two results
// rst is synchronous: scan mode returns to normal text, the input register and the queue empty
module comment_whitespace_stripper_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] kept_byte
  output logic       m_axis_tuser,   // [0] has_byte
  output logic       m_axis_tlast
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // scan state, updated once per processed byte
  cws_pkg::mode_t mode;

  cws_pkg::step_out_t step;
  cws_pkg::result_t   out_res;
  logic               room_for_two;
  logic               advance;
  logic [1:0]         wr_count;
  logic [cws_pkg::FIFO_CNT_W-1:0] fill;

  // the held byte is consumed when the queue can take its worst case
  assign advance       = in_valid && room_for_two;
  assign s_axis_tready = !in_valid || advance;
  assign wr_count      = advance ? step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cws_pkg::MODE_NORMAL;
    end else if (advance) begin
      mode <= step.mode_next;
    end
  end

  cws_step u_step (
    .mode        (mode),
    .text_byte   (in_byte),
    .end_of_text (in_last),
    .step        (step)
  );

  cws_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .wr_count     (wr_count),
    .wr_res0      (step.res0),
    .wr_res1      (step.res1),
    .room_for_two (room_for_two),
    .rd_valid     (m_axis_tvalid),
    .rd_ready     (m_axis_tready),
    .rd_res       (out_res),
    .fill         (fill)
  );

  assign m_axis_tdata = out_res.kept_byte;
  assign m_axis_tuser = out_res.has_byte;
  assign m_axis_tlast = out_res.final_result;

`ifndef SYNTH
  // the queue never overflows its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cws_pkg::FIFO_CNT_W'(cws_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // the last byte of a text always yields at least one result
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |-> (step.count != 2'd0))
    else $error("end of text gave no result");

  // after the last byte the scanner is back in normal text
  a_mode_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (mode == cws_pkg::MODE_NORMAL))
    else $error("scan mode not normal after end of text");

  // an empty result is only ever the final marker
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("empty result without end marker");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for comment_whitespace_stripper_unit: directed and random program texts
// depends on cws_pkg (mode and result types, character constants) and the top level of the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // traffic phases: how often the sender idles and the receiver stalls
  localparam int PH_FREE       = 0;
  localparam int PH_SEND_IDLE  = 1;
  localparam int PH_RECV_STALL = 2;
  localparam int PH_BOTH       = 3;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic       s_axis_tlast = 1'b0;    // end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] kept_byte
  logic       m_axis_tuser;           // [0] has_byte
  logic       m_axis_tlast;           // final_result

  text_item_t       pending_text[$];  // bytes still to be offered to the block
  cws_pkg::result_t expected_out[$];  // results predicted but not yet seen
  cws_pkg::mode_t   scan_state = cws_pkg::MODE_NORMAL;
  int         idle_phase = PH_FREE;
  int         items_pushed = 0;
  int         items_taken = 0;
  int         quiet_cycles = 0;
  int         errors = 0;
  logic       in_taken = 1'b0;

  comment_whitespace_stripper_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction of the cleaned text
  // ---------------------------------------------------------------------------

  function automatic void emit_byte(logic [7:0] b);
    cws_pkg::result_t r;
    r.kept_byte    = b;
    r.has_byte     = 1'b1;
    r.final_result = 1'b0;
    expected_out.push_back(r);
  endfunction

  // plain text outside strings and comments
  function automatic void clean_plain(logic [7:0] b);
    if (b <= cws_pkg::CH_SPACE || b >= cws_pkg::CH_HIGH) begin
      return;  // whitespace, control and high bytes vanish
    end
    if (b == cws_pkg::CH_SLASH) begin
      scan_state = cws_pkg::MODE_SLASH;  // wait one byte to see if a comment opens
    end else if (b == cws_pkg::CH_QUOTE) begin
      emit_byte(b);
      scan_state = cws_pkg::MODE_STRING;
    end else if (b >= cws_pkg::CH_LOW_A && b <= cws_pkg::CH_LOW_Z) begin
      emit_byte(b & cws_pkg::CASE_MASK);
    end else begin
      emit_byte(b);
    end
  endfunction

  function automatic void predict_text_byte(logic [7:0] b, logic last);
    int before_cnt;
    cws_pkg::result_t r;
    before_cnt = expected_out.size();
    case (scan_state)
      cws_pkg::MODE_SLASH: begin
        if (b == cws_pkg::CH_STAR) begin
          scan_state = cws_pkg::MODE_BLOCK;
        end else if (b == cws_pkg::CH_SLASH) begin
          scan_state = cws_pkg::MODE_LINE;
        end else begin
          // lone slash: release it, then treat this byte as plain text
          emit_byte(cws_pkg::CH_SLASH);
          scan_state = cws_pkg::MODE_NORMAL;
          clean_plain(b);
        end
      end
      cws_pkg::MODE_BLOCK: begin
        if (b == cws_pkg::CH_STAR) begin
          scan_state = cws_pkg::MODE_BLOCK_STAR;
        end
      end
      cws_pkg::MODE_BLOCK_STAR: begin
        if (b == cws_pkg::CH_SLASH) begin
          scan_state = cws_pkg::MODE_NORMAL;
        end else if (b != cws_pkg::CH_STAR) begin
          scan_state = cws_pkg::MODE_BLOCK;
        end
      end
      cws_pkg::MODE_LINE: begin
        if (b == cws_pkg::CH_NL) begin
          scan_state = cws_pkg::MODE_NORMAL;
        end
      end
      cws_pkg::MODE_STRING: begin
        emit_byte(b);
        if (b == cws_pkg::CH_QUOTE) begin
          scan_state = cws_pkg::MODE_NORMAL;
        end else if (b == cws_pkg::CH_PCT) begin
          scan_state = cws_pkg::MODE_STR_ESC;
        end
      end
      cws_pkg::MODE_STR_ESC: begin
        emit_byte(b);
        scan_state = cws_pkg::MODE_STRING;
      end
      default: begin
        scan_state = cws_pkg::MODE_NORMAL;
        clean_plain(b);
      end
    endcase

    if (last) begin
      if (scan_state == cws_pkg::MODE_SLASH) begin
        emit_byte(cws_pkg::CH_SLASH);  // flush the held slash at end of text
      end
      if (expected_out.size() == before_cnt) begin
        r.kept_byte    = 8'h00;  // bare end marker
        r.has_byte     = 1'b0;
        r.final_result = 1'b0;
        expected_out.push_back(r);
      end
      r = expected_out.pop_back();
      r.final_result = 1'b1;
      expected_out.push_back(r);
      scan_state = cws_pkg::MODE_NORMAL;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = 1'b0;
    pending_text.push_back(it);
    items_pushed++;
  endfunction

  // flag the most recently queued byte as the end of its text
  function automatic void close_text();
    text_item_t it;
    it = pending_text.pop_back();
    it.end_of_text = 1'b1;
    pending_text.push_back(it);
  endfunction

  function automatic void push_string(string s, bit last);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
    if (last) begin
      close_text();
    end
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // one random text built mostly from well-formed tokens; some are left unclosed
  function automatic void push_random_text();
    int n_tokens;
    int len;
    bit broken;
    n_tokens = $urandom_range(1, 8);
    for (int t = 0; t < n_tokens; t++) begin
      len    = $urandom_range(0, 6);
      broken = chance(12);
      case ($urandom_range(0, 9))
        0, 1: push_byte(printable());
        2: push_byte(8'($urandom_range(8'h61, 8'h7a)));  // lowercase to be folded
        3: begin
          case ($urandom_range(0, 3))
            0: push_byte(cws_pkg::CH_SPACE);
            1: push_byte(cws_pkg::CH_NL);
            2: push_byte(8'h09);
            default: push_byte(8'h00);
          endcase
        end
        4: begin
          // string literal with raw bytes and percent escapes
          push_byte(cws_pkg::CH_QUOTE);
          for (int i = 0; i < len; i++) begin
            if (chance(25)) begin
              push_byte(cws_pkg::CH_PCT);
              push_byte(chance(40) ? cws_pkg::CH_QUOTE : 8'($urandom_range(0, 255)));
            end else begin
              push_byte(chance(70) ? printable() : 8'($urandom_range(0, 255)));
            end
          end
          if (!broken) begin
            push_byte(cws_pkg::CH_QUOTE);
          end
        end
        5: begin
          // block comment with stray stars and slashes inside
          push_byte(cws_pkg::CH_SLASH);
          push_byte(cws_pkg::CH_STAR);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
              0: push_byte(cws_pkg::CH_STAR);
              1: push_byte(cws_pkg::CH_SLASH);
              default: push_byte(8'($urandom_range(0, 255)));
            endcase
          end
          if (!broken) begin
            if (chance(30)) begin
              push_byte(cws_pkg::CH_STAR);
            end
            push_byte(cws_pkg::CH_STAR);
            push_byte(cws_pkg::CH_SLASH);
          end
        end
        6: begin
          // line comment, ended by newline unless broken
          push_byte(cws_pkg::CH_SLASH);
          push_byte(cws_pkg::CH_SLASH);
          for (int i = 0; i < len; i++) begin
            push_byte(printable());
          end
          if (!broken) begin
            push_byte(cws_pkg::CH_NL);
          end
        end
        7: begin
          // lone slash, followed unless broken by a quote or a random printable byte
          push_byte(cws_pkg::CH_SLASH);
          if (!broken) begin
            push_byte(chance(20) ? cws_pkg::CH_QUOTE : printable());
          end
        end
        default: push_byte(8'($urandom_range(0, 255)));  // noise
      endcase
    end
    close_text();
  endfunction

  function automatic void push_directed();
    // bytes at the edges of the kept range
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h80);
    push_byte(8'h7f);
    push_byte(cws_pkg::CH_SPACE);
    // folding and a slash released by a following letter
    push_string("a/z", 1'b0);
    // slash-star-slash stays open, repeated stars then close
    push_string("/*/a**/", 1'b0);
    // line comment dropped along with its newline
    push_string("//q\n", 1'b0);
    // string with escaped quote, zero byte and high byte passing unchanged
    push_string("\"%\"b", 1'b0);
    push_byte(8'h00);
    push_byte(8'hff);
    push_string("\"", 1'b0);
    // held slash flushed at end of text
    push_string("/", 1'b1);
    // text ending with nothing kept gives a bare end marker
    push_string(" ", 1'b1);
    // text ending inside an open block comment
    push_string("/*", 1'b1);
  endfunction

  function automatic int send_idle_pct();
    return (idle_phase == PH_SEND_IDLE) ? 46 : (idle_phase == PH_BOTH) ? 12 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_phase == PH_RECV_STALL) ? 46 : (idle_phase == PH_BOTH) ? 12 : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending bytes at the falling edge, holds them until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    text_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_text.size() != 0 && !chance(send_idle_pct())) begin
        it = pending_text.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.text_byte;
        s_axis_tlast  <= it.end_of_text;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !chance(recv_stall_pct());
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input transaction, checks each output transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cws_pkg::result_t want;
    bit in_fire;
    bit out_fire;
    in_fire  = !rst && s_axis_tvalid && s_axis_tready;
    out_fire = !rst && m_axis_tvalid && m_axis_tready;
    in_taken <= in_fire;

    if (in_fire) begin
      predict_text_byte(s_axis_tdata, s_axis_tlast);
      items_taken++;
    end

    if (out_fire) begin
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte=%h has=%b final=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== want.kept_byte || m_axis_tuser !== want.has_byte ||
            m_axis_tlast !== want.final_result) begin
          $display({"%0t: mismatch, expected byte=%h has=%b final=%b, ",
                    "actual byte=%h has=%b final=%b"},
                   $time, want.kept_byte, want.has_byte, want.final_result,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end
      end
    end

    // watchdog on a stalled interface
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: reset, then one batch of texts per traffic phase
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    target = 0;
    for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
      idle_phase = ph;
      if (ph == PH_FREE) begin
        push_directed();
      end
      target += ITEMS_PER_PHASE;
      while (items_pushed < target) begin
        push_random_text();
      end
      wait (items_taken == items_pushed && expected_out.size() == 0);
      @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
